// ===== rtl/bpfd_pkg.sv =====
// shared types and constants for the bounded packet fifo with duplicate check and range count
package bpfd_pkg;

    localparam int PORT_ID_W    = 16;
    localparam int PORT_TIME_W  = 32;
    localparam int REQ_W        = 2;
    localparam int LIMIT_W      = 7;
    localparam int RANGE_CNT_W  = 7;
    localparam int IN_DATA_W    = 2 * PORT_ID_W + 3 * PORT_TIME_W;
    localparam int OUT_DATA_W   = 1 + 2 * PORT_ID_W + PORT_TIME_W + RANGE_CNT_W;
    localparam int RANGE_CNT_MAX = (1 << RANGE_CNT_W) - 1;

    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FORWARD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COUNT   = 2'd2;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } bpfd_state_t;

    typedef struct packed
    {
        logic clear;
        logic hit_en;
    } bpfd_scan_ctl_t;

endpackage

// ===== rtl/bounded_packet_fifo_dedup_range_count_core.sv =====
// top level: packet ring store with duplicate check, forward and range count
//
// usage
//   s_* channel takes one request word: tuser carries the request code
//   (add, forward oldest, count in range), tdata the packet and time bounds.
//   m_* channel returns exactly one result word per request.
//   cfg_* channel writes memory_limit; write only while the block is idle.
// flow
//   an add or count reads every stored entry from the ring memory, one
//   read a cycle; a forward reads the oldest entry, none on an empty store;
//   other codes read nothing. the result is registered in the finish state,
//   and the next request can be taken once the result is registered; one
//   request is scanned at a time, as the ring memory has a single read port.
// reset
//   the store is empty, oldest pointer zero, memory_limit 64; the memory
//   itself is not cleared, only occupied entries are ever read.
// stall
//   the result sits in the output register until taken; a finished request
//   waits, and no new request is taken, until that register is free.
module bounded_packet_fifo_dedup_range_count_core
    import bpfd_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ID_WIDTH   = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // source, destination, timestamp, start_time, end_time
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [REQ_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // accepted, fwd_source, fwd_destination, fwd_timestamp, range_count
    output logic [OUT_DATA_W-1:0] m_tdata,
    // fwd_valid
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_data
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = PTR_W + 1;
    localparam int CMP_W   = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam int ENTRY_W = 2 * ID_WIDTH + TIME_WIDTH;

    bpfd_state_t           state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [ID_WIDTH-1:0]   src_reg, src_next;
    logic [ID_WIDTH-1:0]   dst_reg, dst_next;
    logic [TIME_WIDTH-1:0] ts_reg, ts_next;
    logic [TIME_WIDTH-1:0] lo_reg, lo_next;
    logic [TIME_WIDTH-1:0] hi_reg, hi_next;
    logic [PTR_W-1:0]      oldest_reg, oldest_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]      issue_reg, issue_next;
    logic [OCC_W-1:0]      len_reg, len_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_user_reg, out_user_next;

    logic                  in_fire;
    logic                  rd_en;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ENTRY_W-1:0]    rd_data;
    logic [ID_WIDTH-1:0]   ent_src;
    logic [ID_WIDTH-1:0]   ent_dst;
    logic [TIME_WIDTH-1:0] ent_ts;
    bpfd_scan_ctl_t        scan_ctl;
    logic                  scan_dup;
    logic [OCC_W-1:0]      scan_count;
    logic [CMP_W-1:0]      eff_limit;
    logic [SUM_W-1:0]      wr_sum;
    logic [CMP_W-1:0]      count_wide;
    logic [RANGE_CNT_W-1:0] count_sat;
    logic                  out_free;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign ent_src = rd_data[ID_WIDTH-1:0];
    assign ent_dst = rd_data[2*ID_WIDTH-1:ID_WIDTH];
    assign ent_ts  = rd_data[ENTRY_W-1:2*ID_WIDTH];

    assign eff_limit = (CMP_W'(limit_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                           : CMP_W'(limit_reg);
    assign wr_sum  = SUM_W'(oldest_reg) + SUM_W'(occ_reg);
    assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                               : PTR_W'(wr_sum);
    assign wr_data = {ts_reg, dst_reg, src_reg};

    assign count_wide = CMP_W'(scan_count);
    assign count_sat  = (count_wide > CMP_W'(RANGE_CNT_MAX)) ? RANGE_CNT_W'(RANGE_CNT_MAX)
                                                             : RANGE_CNT_W'(count_wide);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        ts_next        = ts_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        oldest_next    = oldest_reg;
        occ_next       = occ_reg;
        limit_next     = limit_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_next     = issue_reg;
        len_next       = len_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        scan_ctl       = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next    = s_tuser;
                    src_next    = ID_WIDTH'(s_tdata[PORT_ID_W-1:0]);
                    dst_next    = ID_WIDTH'(s_tdata[2*PORT_ID_W-1:PORT_ID_W]);
                    ts_next     = TIME_WIDTH'(s_tdata[2*PORT_ID_W+PORT_TIME_W-1:
                                                      2*PORT_ID_W]);
                    lo_next     = TIME_WIDTH'(s_tdata[2*PORT_ID_W+2*PORT_TIME_W-1:
                                                      2*PORT_ID_W+PORT_TIME_W]);
                    hi_next     = TIME_WIDTH'(s_tdata[IN_DATA_W-1:
                                                      2*PORT_ID_W+2*PORT_TIME_W]);
                    rd_ptr_next = oldest_reg;
                    issue_next  = '0;
                    if ((s_tuser == REQ_ADD) || (s_tuser == REQ_COUNT))
                    begin
                        len_next = occ_reg;
                    end
                    else if ((s_tuser == REQ_FORWARD) && (occ_reg != '0))
                    begin
                        len_next = OCC_W'(1);
                    end
                    else
                    begin
                        len_next = '0;
                    end
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                rd_en = (issue_reg != len_reg);
                if (rd_en)
                begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    issue_next  = issue_reg + OCC_W'(1);
                end
                pend_next       = rd_en;
                scan_ctl.hit_en = pend_reg && ((req_reg == REQ_ADD) || (req_reg == REQ_COUNT));
                if (!rd_en && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_user_next  = 1'b0;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (!scan_dup)
                            begin
                                wr_en            = 1'b1;
                                out_data_next[0] = 1'b1;
                                if ((CMP_W'(occ_reg) >= eff_limit) && (occ_reg != '0))
                                begin
                                    oldest_next = ptr_inc(oldest_reg);
                                end
                                else
                                begin
                                    occ_next = occ_reg + OCC_W'(1);
                                end
                            end
                        end
                        REQ_FORWARD:
                        begin
                            if (occ_reg != '0)
                            begin
                                out_user_next = 1'b1;
                                out_data_next = {{RANGE_CNT_W{1'b0}},
                                                 PORT_TIME_W'(ent_ts),
                                                 PORT_ID_W'(ent_dst),
                                                 PORT_ID_W'(ent_src),
                                                 1'b0};
                                oldest_next   = ptr_inc(oldest_reg);
                                occ_next      = occ_reg - OCC_W'(1);
                            end
                        end
                        REQ_COUNT:
                        begin
                            out_data_next = {count_sat,
                                             {(OUT_DATA_W-RANGE_CNT_W){1'b0}}};
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            limit_reg     <= LIMIT_W'(64);
            rd_ptr_reg    <= '0;
            issue_reg     <= '0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            occ_reg       <= occ_next;
            limit_reg     <= limit_next;
            rd_ptr_reg    <= rd_ptr_next;
            issue_reg     <= issue_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        ts_reg       <= ts_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    bpfd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    bpfd_scan #(
        .ID_WIDTH   (ID_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .CNT_W      (OCC_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .entry_src (ent_src),
        .entry_dst (ent_dst),
        .entry_ts  (ent_ts),
        .key_src   (src_reg),
        .key_dst   (dst_reg),
        .key_ts    (ts_reg),
        .key_lo    (lo_reg),
        .key_hi    (hi_reg),
        .dup       (scan_dup),
        .count     (scan_count)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/bpfd_ram.sv =====
// generic single-write single-read ram with registered read data
module bpfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bpfd_scan.sv =====
// per-entry compare unit: duplicate flag and range-match counter over a ring scan
module bpfd_scan
    import bpfd_pkg::*;
#(
    parameter int ID_WIDTH   = 16,
    parameter int TIME_WIDTH = 32,
    parameter int CNT_W      = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpfd_scan_ctl_t        ctl,
    input  logic [ID_WIDTH-1:0]   entry_src,
    input  logic [ID_WIDTH-1:0]   entry_dst,
    input  logic [TIME_WIDTH-1:0] entry_ts,
    input  logic [ID_WIDTH-1:0]   key_src,
    input  logic [ID_WIDTH-1:0]   key_dst,
    input  logic [TIME_WIDTH-1:0] key_ts,
    input  logic [TIME_WIDTH-1:0] key_lo,
    input  logic [TIME_WIDTH-1:0] key_hi,
    output logic                  dup,
    output logic [CNT_W-1:0]      count
);

    logic             dup_reg;
    logic             dup_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dst_eq;
    logic             in_range;

    assign dst_eq   = (entry_dst == key_dst);
    assign in_range = (entry_ts >= key_lo) && (entry_ts <= key_hi);

    always_comb
    begin
        dup_next   = dup_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            dup_next   = 1'b0;
            count_next = '0;
        end
        else if (ctl.hit_en)
        begin
            if (dst_eq && (entry_src == key_src) && (entry_ts == key_ts))
            begin
                dup_next = 1'b1;
            end
            if (dst_eq && in_range)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            dup_reg   <= dup_next;
            count_reg <= count_next;
        end
    end

    assign dup   = dup_reg;
    assign count = count_reg;

endmodule
